### sv/mse_pkg.sv
package mse_pkg;

    localparam int PAT_W  = 6;
    localparam int LEN_W  = 3;
    localparam int STEP_W = 4;

    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [1:0] {
        SYM_DOT   = 2'd0,
        SYM_DASH  = 2'd1,
        SYM_GAP   = 2'd2,
        SYM_SLASH = 2'd3
    } sym_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_PAT,
        KIND_SPACE,
        KIND_PCT
    } kind_t;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_PAT,
        EMIT_GAP,
        EMIT_SLASH
    } emit_t;

    typedef enum logic [1:0] {
        LD_NONE,
        LD_IN,
        LD_ZERO,
        LD_SLASH
    } load_t;

    typedef enum logic [1:0] {
        CND_GO,
        CND_LOOP,
        CND_DISPATCH
    } cond_t;

    typedef struct packed {
        kind_t             kind;
        logic [LEN_W-1:0]  len;
        logic [PAT_W-1:0]  bits;
    } pat_t;

    typedef struct packed {
        emit_t emit;
        logic  last;
        load_t load;
        cond_t cond;
        step_t target;
    } ucode_t;

    localparam step_t ST_IDLE  = 4'd0;
    localparam step_t ST_PAT   = 4'd1;
    localparam step_t ST_END   = 4'd2;
    localparam step_t ST_SLASH = 4'd3;
    localparam step_t ST_PZ1   = 4'd4;
    localparam step_t ST_PG1   = 4'd5;
    localparam step_t ST_PS    = 4'd6;
    localparam step_t ST_PG2   = 4'd7;
    localparam step_t ST_PZ2   = 4'd8;

    localparam pat_t PAT_ZERO  = '{KIND_PAT, 3'd5, 6'b011111};
    localparam pat_t PAT_SLASH = '{KIND_PAT, 3'd5, 6'b001001};

    // first symbol in bit 0, dash = 1
    function automatic pat_t lookup(input logic [7:0] c);
        pat_t r;
        r = '{KIND_NONE, 3'd0, 6'b000000};
        case (c)
            8'h41: r = '{KIND_PAT, 3'd2, 6'b000010};
            8'h42: r = '{KIND_PAT, 3'd4, 6'b000001};
            8'h43: r = '{KIND_PAT, 3'd4, 6'b000101};
            8'h44: r = '{KIND_PAT, 3'd3, 6'b000001};
            8'h45: r = '{KIND_PAT, 3'd1, 6'b000000};
            8'h46: r = '{KIND_PAT, 3'd4, 6'b000100};
            8'h47: r = '{KIND_PAT, 3'd3, 6'b000011};
            8'h48: r = '{KIND_PAT, 3'd4, 6'b000000};
            8'h49: r = '{KIND_PAT, 3'd2, 6'b000000};
            8'h4A: r = '{KIND_PAT, 3'd4, 6'b001110};
            8'h4B: r = '{KIND_PAT, 3'd3, 6'b000101};
            8'h4C: r = '{KIND_PAT, 3'd4, 6'b000010};
            8'h4D: r = '{KIND_PAT, 3'd2, 6'b000011};
            8'h4E: r = '{KIND_PAT, 3'd2, 6'b000001};
            8'h4F: r = '{KIND_PAT, 3'd3, 6'b000111};
            8'h50: r = '{KIND_PAT, 3'd4, 6'b000110};
            8'h51: r = '{KIND_PAT, 3'd4, 6'b001011};
            8'h52: r = '{KIND_PAT, 3'd3, 6'b000010};
            8'h53: r = '{KIND_PAT, 3'd3, 6'b000000};
            8'h54: r = '{KIND_PAT, 3'd1, 6'b000001};
            8'h55: r = '{KIND_PAT, 3'd3, 6'b000100};
            8'h56: r = '{KIND_PAT, 3'd4, 6'b001000};
            8'h57: r = '{KIND_PAT, 3'd3, 6'b000110};
            8'h58: r = '{KIND_PAT, 3'd4, 6'b001001};
            8'h59: r = '{KIND_PAT, 3'd4, 6'b001101};
            8'h5A: r = '{KIND_PAT, 3'd4, 6'b000011};
            8'h30: r = '{KIND_PAT, 3'd5, 6'b011111};
            8'h31: r = '{KIND_PAT, 3'd5, 6'b011110};
            8'h32: r = '{KIND_PAT, 3'd5, 6'b011100};
            8'h33: r = '{KIND_PAT, 3'd5, 6'b011000};
            8'h34: r = '{KIND_PAT, 3'd5, 6'b010000};
            8'h35: r = '{KIND_PAT, 3'd5, 6'b000000};
            8'h36: r = '{KIND_PAT, 3'd5, 6'b000001};
            8'h37: r = '{KIND_PAT, 3'd5, 6'b000011};
            8'h38: r = '{KIND_PAT, 3'd5, 6'b000111};
            8'h39: r = '{KIND_PAT, 3'd5, 6'b001111};
            8'h26: r = '{KIND_PAT, 3'd5, 6'b000010};
            8'h27: r = '{KIND_PAT, 3'd6, 6'b011110};
            8'h40: r = '{KIND_PAT, 3'd6, 6'b010110};
            8'h29: r = '{KIND_PAT, 3'd6, 6'b101101};
            8'h28: r = '{KIND_PAT, 3'd5, 6'b001101};
            8'h3A: r = '{KIND_PAT, 3'd6, 6'b000111};
            8'h2C: r = '{KIND_PAT, 3'd6, 6'b110011};
            8'h3D: r = '{KIND_PAT, 3'd5, 6'b010001};
            8'h21: r = '{KIND_PAT, 3'd6, 6'b110101};
            8'h2E: r = '{KIND_PAT, 3'd6, 6'b101010};
            8'h2D: r = '{KIND_PAT, 3'd6, 6'b100001};
            8'h78: r = '{KIND_PAT, 3'd4, 6'b001001};
            8'h25: r = '{KIND_PCT, 3'd5, 6'b011111};
            8'h2B: r = '{KIND_PAT, 3'd5, 6'b001010};
            8'h22: r = '{KIND_PAT, 3'd6, 6'b010010};
            8'h3F: r = '{KIND_PAT, 3'd6, 6'b001100};
            8'h2F: r = '{KIND_PAT, 3'd5, 6'b001001};
            8'h20: r = '{KIND_SPACE, 3'd0, 6'b000000};
            default: r = '{KIND_NONE, 3'd0, 6'b000000};
        endcase
        return r;
    endfunction

    function automatic step_t dispatch(input kind_t k);
        step_t s;
        case (k)
            KIND_PAT:   s = ST_PAT;
            KIND_SPACE: s = ST_SLASH;
            KIND_PCT:   s = ST_PZ1;
            default:    s = ST_IDLE;
        endcase
        return s;
    endfunction

    function automatic ucode_t ucode(input step_t s);
        ucode_t u;
        case (s)
            ST_IDLE:  u = '{EMIT_NONE,  1'b0, LD_IN,    CND_DISPATCH, ST_IDLE};
            ST_PAT:   u = '{EMIT_PAT,   1'b0, LD_NONE,  CND_LOOP,     ST_END};
            ST_END:   u = '{EMIT_GAP,   1'b1, LD_NONE,  CND_GO,       ST_IDLE};
            ST_SLASH: u = '{EMIT_SLASH, 1'b0, LD_NONE,  CND_GO,       ST_END};
            ST_PZ1:   u = '{EMIT_PAT,   1'b0, LD_NONE,  CND_LOOP,     ST_PG1};
            ST_PG1:   u = '{EMIT_GAP,   1'b0, LD_SLASH, CND_GO,       ST_PS};
            ST_PS:    u = '{EMIT_PAT,   1'b0, LD_NONE,  CND_LOOP,     ST_PG2};
            ST_PG2:   u = '{EMIT_GAP,   1'b0, LD_ZERO,  CND_GO,       ST_PZ2};
            ST_PZ2:   u = '{EMIT_PAT,   1'b0, LD_NONE,  CND_LOOP,     ST_END};
            default:  u = '{EMIT_NONE,  1'b0, LD_NONE,  CND_GO,       ST_IDLE};
        endcase
        return u;
    endfunction

endpackage

### sv/morse_symbol_encoder.sv
// The first symbol word is registered by the step that follows the accepting dispatch step.
// Throughput: one symbol per cycle from the microcode step counter while m_tready allows,
// plus one dispatch step per character; an unlisted character emits nothing.
// The next character is accepted in the dispatch step while the last symbol still waits.
// Reset: step counter returns to dispatch and the output word is dropped.
module morse_symbol_encoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] character
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [1:0] symbol, [7:2] zero
    output logic       m_tlast    // last
);

    mse_pkg::step_t                   pc_reg, pc_next;
    logic [mse_pkg::PAT_W-1:0]        pat_reg, pat_next;
    logic [mse_pkg::LEN_W-1:0]        cnt_reg, cnt_next;
    logic                             valid_reg, valid_next;
    mse_pkg::sym_t                    sym_reg, sym_next;
    logic                             last_reg, last_next;

    mse_pkg::ucode_t uw;
    mse_pkg::pat_t   lk;
    logic            adv;
    logic            fire;
    logic            disp;

    always_comb
    begin
        uw   = mse_pkg::ucode(pc_reg);
        lk   = mse_pkg::lookup(s_tdata);
        disp = (uw.cond == mse_pkg::CND_DISPATCH);
        adv  = !valid_reg || m_tready;
        fire = disp ? s_tvalid : adv;

        pc_next    = pc_reg;
        pat_next   = pat_reg;
        cnt_next   = cnt_reg;
        sym_next   = sym_reg;
        last_next  = last_reg;
        valid_next = valid_reg && !m_tready;

        if (fire)
        begin
            case (uw.emit)
                mse_pkg::EMIT_PAT:
                begin
                    valid_next = 1'b1;
                    sym_next   = pat_reg[0] ? mse_pkg::SYM_DASH : mse_pkg::SYM_DOT;
                    last_next  = uw.last;
                    pat_next   = pat_reg >> 1;
                    cnt_next   = cnt_reg - 1'b1;
                end
                mse_pkg::EMIT_GAP:
                begin
                    valid_next = 1'b1;
                    sym_next   = mse_pkg::SYM_GAP;
                    last_next  = uw.last;
                end
                mse_pkg::EMIT_SLASH:
                begin
                    valid_next = 1'b1;
                    sym_next   = mse_pkg::SYM_SLASH;
                    last_next  = uw.last;
                end
                default:
                begin
                end
            endcase

            case (uw.load)
                mse_pkg::LD_IN:
                begin
                    pat_next = lk.bits;
                    cnt_next = lk.len;
                end
                mse_pkg::LD_ZERO:
                begin
                    pat_next = mse_pkg::PAT_ZERO.bits;
                    cnt_next = mse_pkg::PAT_ZERO.len;
                end
                mse_pkg::LD_SLASH:
                begin
                    pat_next = mse_pkg::PAT_SLASH.bits;
                    cnt_next = mse_pkg::PAT_SLASH.len;
                end
                default:
                begin
                end
            endcase

            case (uw.cond)
                mse_pkg::CND_DISPATCH: pc_next = mse_pkg::dispatch(lk.kind);
                mse_pkg::CND_LOOP:     pc_next = (cnt_reg == 3'd1) ? uw.target : pc_reg;
                default:               pc_next = uw.target;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg    <= mse_pkg::ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg    <= pc_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pat_reg  <= pat_next;
        cnt_reg  <= cnt_next;
        sym_reg  <= sym_next;
        last_reg <= last_next;
    end

    assign s_tready = disp;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'b000000, sym_reg};
    assign m_tlast  = last_reg;

endmodule
